@@ rtl/divide_cycle_timing_macros.svh @@
// Assertion macros for the divide cycle timing block.
`ifndef DIVIDE_CYCLE_TIMING_MACROS_SVH
`define DIVIDE_CYCLE_TIMING_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is ignored while reset is asserted.
`define DCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DCT_ASSERT(label, clk, rst_n, prop, msg)
`define DCT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/dct_pkg.sv @@
// Shared types, constants and the divide walk step for the divide cycle timing block.
package dct_pkg;

    // Operation codes.
    typedef enum logic {
        OP_UNSIGNED = 1'b0,
        OP_SIGNED   = 1'b1
    } t_op;

    // Widths.
    localparam int C_DVD_W = 32;
    localparam int C_DVS_W = 16;
    localparam int C_CNT_W = 7;
    localparam int C_OUT_W = 8;

    // Number of shift-subtract steps in the walk.
    localparam int C_STEPS = 15;

    // Queue depth between front and back.
    localparam int C_Q_DEPTH = 2;
    localparam int C_Q_PTR_W = $clog2(C_Q_DEPTH);
    localparam int C_Q_CNT_W = $clog2(C_Q_DEPTH + 1);

    // Base counts (half cycles; the result is twice the count).
    localparam logic [C_CNT_W-1:0] C_U_BASE    = 7'd38;
    localparam logic [C_CNT_W-1:0] C_U_FAST    = 7'd10;
    localparam logic [C_CNT_W-1:0] C_S_BASE    = 7'd55;
    localparam logic [C_CNT_W-1:0] C_S_FAST    = 7'd21;
    localparam logic [C_CNT_W-1:0] C_SIGN_BASE = 7'd6;
    localparam logic [C_CNT_W-1:0] C_U_OVF     = 7'd5;
    localparam logic [C_CNT_W-1:0] C_S_OVF_ADD = 7'd2;

    // One classified divide job as it moves through queue and back end.
    typedef struct packed {
        t_op                 op;
        logic                ovf;
        logic [C_CNT_W-1:0]  count;
        logic [C_DVS_W-1:0]  rem;
        logic [C_DVS_W-1:0]  low;
        logic [C_DVS_W-1:0]  dvs;
    } t_job;

    // One step of the shift-subtract walk with its cycle bookkeeping.
    function automatic t_job walk_step(input t_job j);
        t_job               n;
        logic [C_DVS_W:0]   t;
        logic               ge;
        logic [C_CNT_W-1:0] inc;
        n  = j;
        t  = {j.rem, j.low[C_DVS_W-1]};
        ge = (t >= {1'b0, j.dvs});
        if (ge) begin
            n.rem = C_DVS_W'(t - {1'b0, j.dvs});
        end else begin
            n.rem = t[C_DVS_W-1:0];
        end
        n.low = {j.low[C_DVS_W-2:0], 1'b0};
        if (j.ovf) begin
            inc = '0;
        end else if (j.op == OP_SIGNED) begin
            inc = ge ? C_CNT_W'(0) : C_CNT_W'(1);
        end else if (j.rem[C_DVS_W-1]) begin
            inc = '0;
        end else begin
            inc = ge ? C_CNT_W'(1) : C_CNT_W'(2);
        end
        n.count = j.count + inc;
        return n;
    endfunction

endpackage

@@ rtl/dct_front.sv @@
// Front end: takes divide requests, forms operand magnitudes and classifies them.
module dct_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_operation,
    input  logic [dct_pkg::C_DVD_W-1:0]   i_dividend,
    input  logic [dct_pkg::C_DVS_W-1:0]   i_divisor,
    input  logic                          i_fast_mode,
    input  logic                          i_q_full,
    output logic                          o_busy,
    output logic                          o_push,
    output dct_pkg::t_job                 o_job
);

    logic                          w_adv;
    logic                          w_dneg;
    logic                          w_vneg;
    logic                          w_ovf;
    logic [dct_pkg::C_CNT_W-1:0]   w_count;
    logic [dct_pkg::C_CNT_W-1:0]   w_sbase;

    // Stage one registers.
    logic                          r_s1_valid;
    dct_pkg::t_op                  r_op;
    logic                          r_fast;
    logic                          r_dneg;
    logic                          r_vneg;
    logic [dct_pkg::C_DVD_W-1:0]   r_mag_d;
    logic [dct_pkg::C_DVS_W-1:0]   r_mag_v;

    // Stage two registers.
    logic                          r_s2_valid;
    dct_pkg::t_job                 r_job;

    // The whole front moves as one unit and holds while stage two has a job and the queue is full.
    assign w_adv  = !(r_s2_valid && i_q_full);
    assign o_busy = !w_adv;
    assign o_push = r_s2_valid && !i_q_full;
    assign o_job  = r_job;

    // Operand signs only matter for signed divides.
    assign w_dneg = i_operation && i_dividend[dct_pkg::C_DVD_W-1];
    assign w_vneg = i_operation && i_divisor[dct_pkg::C_DVS_W-1];

    // Stage one: magnitudes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_start;
        end
        if (w_adv) begin
            r_op    <= dct_pkg::t_op'(i_operation);
            r_fast  <= i_fast_mode;
            r_dneg  <= w_dneg;
            r_vneg  <= w_vneg;
            r_mag_d <= w_dneg ? (~i_dividend + 1'b1) : i_dividend;
            r_mag_v <= w_vneg ? (~i_divisor + 1'b1) : i_divisor;
        end
    end

    // Stage two: overflow test and starting count.
    assign w_ovf   = (r_mag_d[dct_pkg::C_DVD_W-1 -: dct_pkg::C_DVS_W] >= r_mag_v);
    assign w_sbase = r_fast ? dct_pkg::C_S_FAST : dct_pkg::C_S_BASE;

    always_comb begin
        w_count = '0;
        unique case (r_op)
            dct_pkg::OP_UNSIGNED: begin
                if (w_ovf) begin
                    w_count = dct_pkg::C_U_OVF;
                end else begin
                    w_count = r_fast ? dct_pkg::C_U_FAST : dct_pkg::C_U_BASE;
                end
            end
            dct_pkg::OP_SIGNED: begin
                w_count = dct_pkg::C_SIGN_BASE + dct_pkg::C_CNT_W'(r_dneg);
                if (w_ovf) begin
                    w_count = w_count + dct_pkg::C_S_OVF_ADD;
                end else if (r_vneg) begin
                    w_count = w_count + w_sbase;
                end else if (r_dneg) begin
                    w_count = w_count + w_sbase + dct_pkg::C_CNT_W'(1);
                end else begin
                    w_count = w_count + w_sbase - dct_pkg::C_CNT_W'(1);
                end
            end
            default: w_count = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_adv) begin
            r_job.op    <= r_op;
            r_job.ovf   <= w_ovf;
            r_job.count <= w_count;
            r_job.rem   <= r_mag_d[dct_pkg::C_DVD_W-1 -: dct_pkg::C_DVS_W];
            r_job.low   <= r_mag_d[dct_pkg::C_DVS_W-1:0];
            r_job.dvs   <= r_mag_v;
        end
    end

endmodule

@@ rtl/dct_queue.sv @@
// Short job queue between the front end and the divide walk.
module dct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dct_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_pop,
    output dct_pkg::t_job  o_job
);

    dct_pkg::t_job                    r_mem [dct_pkg::C_Q_DEPTH];
    logic [dct_pkg::C_Q_PTR_W-1:0]    r_wr_ptr;
    logic [dct_pkg::C_Q_PTR_W-1:0]    r_rd_ptr;
    logic [dct_pkg::C_Q_CNT_W-1:0]    r_count;
    logic [dct_pkg::C_Q_PTR_W-1:0]    n_wr_ptr;
    logic [dct_pkg::C_Q_PTR_W-1:0]    n_rd_ptr;

    // The back end never stalls, so the head leaves whenever there is one.
    assign o_pop  = (r_count != '0);
    assign o_full = (r_count == dct_pkg::C_Q_CNT_W'(dct_pkg::C_Q_DEPTH));
    assign o_job  = r_mem[r_rd_ptr];

    // Pointer wrap.
    always_comb begin
        if (r_wr_ptr == dct_pkg::C_Q_PTR_W'(dct_pkg::C_Q_DEPTH - 1)) begin
            n_wr_ptr = '0;
        end else begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (r_rd_ptr == dct_pkg::C_Q_PTR_W'(dct_pkg::C_Q_DEPTH - 1)) begin
            n_rd_ptr = '0;
        end else begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (o_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !o_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && o_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ rtl/dct_back.sv @@
// Back end: pipelined shift-subtract walk, one step per stage, and the result register.
module dct_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dct_pkg::t_job                 i_job,
    output logic                          o_strobe,
    output logic [dct_pkg::C_OUT_W-1:0]   o_cycle_count
);

    logic            r_vld [dct_pkg::C_STEPS];
    dct_pkg::t_job   r_job [dct_pkg::C_STEPS];
    dct_pkg::t_job   n_job [dct_pkg::C_STEPS];
    logic            r_strobe;
    logic [dct_pkg::C_OUT_W-1:0] r_cycle_count;

    // Each stage applies one walk step to the job of the stage before it.
    always_comb begin
        n_job[0] = dct_pkg::walk_step(i_job);
        for (int k = 1; k < dct_pkg::C_STEPS; k++) begin
            n_job[k] = dct_pkg::walk_step(r_job[k-1]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dct_pkg::C_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < dct_pkg::C_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_strobe <= r_vld[dct_pkg::C_STEPS-1];
        end
    end

    // Stage payloads and the doubled final count.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < dct_pkg::C_STEPS; k++) begin
            r_job[k] <= n_job[k];
        end
        r_cycle_count <= {r_job[dct_pkg::C_STEPS-1].count, 1'b0};
    end

    assign o_strobe      = r_strobe;
    assign o_cycle_count = r_cycle_count;

endmodule

@@ rtl/divide_cycle_timing.sv @@
// Top level of the divide cycle timing block.
//
//  Channel   | Handshake                    | Payload
//  ----------+------------------------------+---------------------------------
//  request   | start / busy                 | i_operation, i_dividend, i_divisor
//  result    | o_strobe                     | o_cycle_count
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_fast_mode
//
// One request can be taken every clock cycle. Two front stages, one queue slot
// and the 15-stage walk pipeline come before the result register, which raises
// the strobe and holds the cycle count.
// Reset is synchronous and active low; it clears every in-flight request and
// returns fast mode to off. Results cannot be held off by the receiver, so
// the walk never stalls, the queue drains every cycle and busy stays low.
`include "divide_cycle_timing_macros.svh"

module divide_cycle_timing (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [dct_pkg::C_DVD_W-1:0]   i_dividend,
    input  logic [dct_pkg::C_DVS_W-1:0]   i_divisor,
    output logic                          o_strobe,
    output logic [dct_pkg::C_OUT_W-1:0]   o_cycle_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_fast_mode
);

    logic           r_fast_mode;
    logic           w_q_full;
    logic           w_push;
    logic           w_pop;
    dct_pkg::t_job  w_front_job;
    dct_pkg::t_job  w_head_job;
    logic           w_req_taken;
    logic           w_uzero_taken;
    logic           w_early_out;

    // Fast-mode configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fast_mode <= i_cfg_fast_mode;
        end
    end

    // Request intake and classification.
    dct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .i_fast_mode (r_fast_mode),
        .i_q_full    (w_q_full),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    // Decoupling queue.
    dct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .o_pop   (w_pop),
        .o_job   (w_head_job)
    );

    // Divide walk and result.
    dct_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_pop),
        .i_job         (w_head_job),
        .o_strobe      (o_strobe),
        .o_cycle_count (o_cycle_count)
    );

    // Terms used by the checks below.
    assign w_req_taken   = start && !busy;
    assign w_uzero_taken = w_req_taken && (i_divisor == '0)
                           && (dct_pkg::t_op'(i_operation) == dct_pkg::OP_UNSIGNED);
    assign w_early_out   = (o_cycle_count == 8'd10);

    // Every taken request gives its result strobe once it has passed through the pipeline.
    `DCT_ASSERT(a_latency, i_clk, i_rst_n, w_req_taken |-> ##19 o_strobe, "result missing")

    // An unsigned divide by zero always costs the overflow early-out.
    `DCT_ASSERT(a_udiv_zero, i_clk, i_rst_n, w_uzero_taken |-> ##19 w_early_out, "no early-out")

    // Since the walk always drains, the front end never has to hold a request.
    `DCT_ASSERT_ALWAYS(a_no_stall, i_clk, !i_rst_n || !busy, "front end stalled")

    // No divide can cost more than the signed worst case.
    `DCT_ASSERT(a_max_count, i_clk, i_rst_n, o_strobe |-> (o_cycle_count <= 8'd156), "count too high")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for divide_cycle_timing against a cycle-cost predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_PRINTED = 50;

    // Base constants of the timing formulas, in half cycles.
    localparam int unsigned U_BASE_NORMAL = 38;
    localparam int unsigned U_BASE_FAST   = 10;
    localparam int unsigned S_BASE_NORMAL = 55;
    localparam int unsigned S_BASE_FAST   = 21;
    localparam int unsigned S_SIGN_BASE   = 6;
    localparam int unsigned WALK_STEPS    = 15;
    localparam logic [7:0]  U_OVF_CYCLES  = 8'd10;

    // Kinds of work the driver takes from its plan.
    typedef enum logic [1:0] {
        STEP_DIVIDE,
        STEP_SET_FAST,
        STEP_DRAIN
    } t_plan_kind;

    typedef struct {
        t_plan_kind                  kind;
        dct_pkg::t_op                op;
        logic [dct_pkg::C_DVD_W-1:0] dvd;
        logic [dct_pkg::C_DVS_W-1:0] dvs;
        logic                        fast;
    } t_plan_step;

    typedef struct {
        dct_pkg::t_op                op;
        logic [dct_pkg::C_DVD_W-1:0] dvd;
        logic [dct_pkg::C_DVS_W-1:0] dvs;
        logic                        fast;
        logic [dct_pkg::C_OUT_W-1:0] cycles;
    } t_divide_cost;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_operation = 1'b0;
    logic [dct_pkg::C_DVD_W-1:0] i_dividend = '0;
    logic [dct_pkg::C_DVS_W-1:0] i_divisor = '0;
    logic                        o_strobe;
    logic [dct_pkg::C_OUT_W-1:0] o_cycle_count;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic                        i_cfg_fast_mode = 1'b0;

    t_plan_step   divide_plan[$];
    t_divide_cost pending_costs[$];
    int           outstanding = 0;
    int           gap_left = 0;
    int           burst_left = 0;
    logic         pred_fast = 1'b0;
    int           n_errors = 0;
    int           n_costs_checked = 0;
    int           n_unsigned = 0;
    int           n_signed = 0;
    int           n_fast_writes = 0;

    divide_cycle_timing u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_dividend      (i_dividend),
        .i_divisor       (i_divisor),
        .o_strobe        (o_strobe),
        .o_cycle_count   (o_cycle_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_fast_mode (i_cfg_fast_mode)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Cycle cost of one divide instruction for the given operands and mode.
    function automatic logic [dct_pkg::C_OUT_W-1:0] divide_cost(
        dct_pkg::t_op                op,
        logic [dct_pkg::C_DVD_W-1:0] dvd,
        logic [dct_pkg::C_DVS_W-1:0] dvs,
        logic                        fast
    );
        int unsigned                 half;
        int unsigned                 step_i;
        logic [dct_pkg::C_DVD_W-1:0] rem;
        logic [dct_pkg::C_DVD_W-1:0] hdiv;
        logic [dct_pkg::C_DVD_W-1:0] mag_d;
        logic [dct_pkg::C_DVD_W-1:0] quot;
        logic [dct_pkg::C_DVS_W-1:0] mag_v;
        logic                        dneg;
        logic                        vneg;
        if (op == dct_pkg::OP_UNSIGNED) begin
            // Quotient overflow is detected up front and costs a fixed amount.
            if (dvd[31:16] >= dvs) begin
                return U_OVF_CYCLES;
            end
            half = fast ? U_BASE_FAST : U_BASE_NORMAL;
            rem  = dvd;
            hdiv = {dvs, 16'h0000};
            // Replay the shift-subtract walk; only steps without a carry out cost cycles.
            for (step_i = 0; step_i < WALK_STEPS; step_i++) begin
                if (rem[31]) begin
                    rem = (rem << 1) - hdiv;
                end else begin
                    rem  = rem << 1;
                    half = half + 2;
                    if (rem >= hdiv) begin
                        rem  = rem - hdiv;
                        half = half - 1;
                    end
                end
            end
            return dct_pkg::C_OUT_W'(half * 2);
        end
        // Signed timing works on magnitudes; the most negative values stay as their own magnitude.
        dneg  = dvd[31];
        vneg  = dvs[15];
        mag_d = dneg ? -dvd : dvd;
        mag_v = vneg ? -dvs : dvs;
        half  = dneg ? S_SIGN_BASE + 1 : S_SIGN_BASE;
        if (mag_d[31:16] >= mag_v) begin
            return dct_pkg::C_OUT_W'((half + 2) * 2);
        end
        half = half + (fast ? S_BASE_FAST : S_BASE_NORMAL);
        if (!vneg) begin
            half = dneg ? half + 1 : half - 1;
        end
        // Each zero among quotient bits 15 down to 1 adds one half cycle pair.
        quot = mag_d / {16'h0000, mag_v};
        for (step_i = 1; step_i <= WALK_STEPS; step_i++) begin
            if (!quot[step_i]) begin
                half = half + 1;
            end
        end
        return dct_pkg::C_OUT_W'(half * 2);
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic queue_divide(dct_pkg::t_op op, logic [dct_pkg::C_DVD_W-1:0] dvd,
                                logic [dct_pkg::C_DVS_W-1:0] dvs);
        divide_plan.push_back('{kind: STEP_DIVIDE, op: op, dvd: dvd, dvs: dvs, fast: 1'b0});
    endtask

    task automatic queue_control(t_plan_kind kind, logic fast);
        divide_plan.push_back('{kind: kind, op: dct_pkg::OP_UNSIGNED, dvd: '0, dvs: '0,
                                fast: fast});
    endtask

    // Driver: presents planned requests and register writes, with random gaps.
    always @(posedge i_clk) begin : driver
        logic nxt_start;
        logic nxt_cfg;
        int   pick;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left     = 0;
        end else begin
            nxt_start = start;
            nxt_cfg   = i_cfg_valid;
            // A request transaction completed: retire it and choose the next gap.
            if (start && !busy) begin
                void'(divide_plan.pop_front());
                nxt_start = 1'b0;
                pick      = $urandom_range(0, 99);
                if (burst_left > 0) begin
                    burst_left--;
                    gap_left = 0;
                end else if (pick < 3) begin
                    burst_left = $urandom_range(30, 80);
                    gap_left   = 0;
                end else if (pick < 38) begin
                    gap_left = 0;
                end else if (pick < 80) begin
                    gap_left = $urandom_range(1, 3);
                end else if (pick < 95) begin
                    gap_left = $urandom_range(4, 10);
                end else begin
                    gap_left = $urandom_range(20, 60);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                void'(divide_plan.pop_front());
                nxt_cfg = 1'b0;
            end
            // Start the next planned step once the gap has run out.
            if (!nxt_start && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (divide_plan.size() > 0) begin
                    case (divide_plan[0].kind)
                        STEP_DIVIDE: begin
                            nxt_start = 1'b1;
                            i_operation <= divide_plan[0].op;
                            i_dividend  <= divide_plan[0].dvd;
                            i_divisor   <= divide_plan[0].dvs;
                        end
                        STEP_SET_FAST: begin
                            if (!start && outstanding == 0) begin
                                nxt_cfg = 1'b1;
                                i_cfg_fast_mode <= divide_plan[0].fast;
                            end
                        end
                        default: begin
                            if (!start && outstanding == 0) begin
                                void'(divide_plan.pop_front());
                            end
                        end
                    endcase
                end
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: predicts each accepted request and checks each strobed result.
    always @(posedge i_clk) begin : monitor
        t_divide_cost want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_costs.size() == 0) begin
                    report_mismatch($sformatf("cycle count %0d with no request outstanding",
                                              o_cycle_count));
                end else begin
                    want = pending_costs.pop_front();
                    n_costs_checked++;
                    if (o_cycle_count !== want.cycles) begin
                        report_mismatch($sformatf(
                            "%s dividend=%h divisor=%h fast=%0d: got %0d, expected %0d",
                            (want.op == dct_pkg::OP_SIGNED) ? "signed" : "unsigned",
                            want.dvd, want.dvs, want.fast, o_cycle_count, want.cycles));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                pred_fast = i_cfg_fast_mode;
                n_fast_writes++;
            end
            if (start && !busy) begin
                want.op     = dct_pkg::t_op'(i_operation);
                want.dvd    = i_dividend;
                want.dvs    = i_divisor;
                want.fast   = pred_fast;
                want.cycles = divide_cost(want.op, i_dividend, i_divisor, pred_fast);
                pending_costs.push_back(want);
                if (want.op == dct_pkg::OP_SIGNED) begin
                    n_signed++;
                end else begin
                    n_unsigned++;
                end
            end
            outstanding <= pending_costs.size();
        end
    end

    // Stimulus plan, reset, end of run.
    initial begin : stimulus
        int                          phase;
        int                          k;
        int                          cls;
        dct_pkg::t_op                op;
        logic [dct_pkg::C_DVD_W-1:0] dvd;
        logic [dct_pkg::C_DVD_W-1:0] mag_d;
        logic [dct_pkg::C_DVS_W-1:0] dvs;
        logic [dct_pkg::C_DVS_W-1:0] mag_v;
        logic [dct_pkg::C_DVS_W-1:0] hi;
        logic                        dneg;
        logic                        vneg;

        // Directed: zero divisor, overflow, carry-out steps and the most negative operands.
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h0000_0000, 16'h0000);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h0000_0000, 16'h0001);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 16'hFFFF);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'hFFFE_FFFF, 16'hFFFF);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h0000_FFFF, 16'hFFFF);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h7FFF_FFFF, 16'h8000);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h0000_0001, 16'h0002);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h8000_0000, 16'h8001);
        queue_divide(dct_pkg::OP_SIGNED, 32'h8000_0000, 16'h0001);
        queue_divide(dct_pkg::OP_SIGNED, 32'h8000_0000, 16'hFFFF);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_1234, 16'h0000);
        queue_divide(dct_pkg::OP_SIGNED, 32'hFFFF_EDCC, 16'h0000);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_0000, 16'h8000);
        queue_divide(dct_pkg::OP_SIGNED, 32'hFFFF_FFFF, 16'hFFFF);
        queue_divide(dct_pkg::OP_SIGNED, 32'h7FFF_FFFF, 16'h7FFF);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_7FFF, 16'h0001);
        queue_divide(dct_pkg::OP_SIGNED, 32'hFFFF_FF9C, 16'h0007);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_0064, 16'hFFF9);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_7FFF, 16'h8000);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_0000, 16'h0001);
        queue_control(STEP_SET_FAST, 1'b1);
        queue_divide(dct_pkg::OP_UNSIGNED, 32'h0000_FFFF, 16'hFFFF);
        queue_divide(dct_pkg::OP_SIGNED, 32'h0000_0064, 16'h0007);
        queue_divide(dct_pkg::OP_SIGNED, 32'hFFFF_FF9C, 16'hFFF9);
        queue_divide(dct_pkg::OP_SIGNED, 32'h7FFF_FFFF, 16'h8000);

        // Random phases; each starts with a fast-mode write, including a rewrite of the same value.
        for (phase = 0; phase < 6; phase++) begin
            queue_control(STEP_SET_FAST, (phase == 1 || phase == 2 || phase == 4));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                op  = dct_pkg::t_op'($urandom_range(0, 1));
                cls = $urandom_range(0, 99);
                if (cls < 60) begin
                    // Operands that pass the overflow test and reach the full walk.
                    if (op == dct_pkg::OP_UNSIGNED) begin
                        dvs = 16'($urandom_range(1, 16'hFFFF));
                        hi  = 16'($urandom_range(0, dvs - 1));
                        dvd = {hi, 16'($urandom)};
                    end else begin
                        vneg  = 1'($urandom_range(0, 1));
                        dneg  = 1'($urandom_range(0, 1));
                        mag_v = 16'($urandom_range(1, vneg ? 32768 : 32767));
                        dvs   = vneg ? -mag_v : mag_v;
                        hi    = 16'($urandom_range(0, mag_v - 1));
                        mag_d = {hi, 16'($urandom)};
                        dvd   = dneg ? -mag_d : mag_d;
                    end
                end else if (cls < 85) begin
                    dvd = $urandom;
                    dvs = 16'($urandom);
                end else begin
                    case ($urandom_range(0, 5))
                        0: dvd = 32'h0000_0000;
                        1: dvd = 32'h0000_0001;
                        2: dvd = 32'h7FFF_FFFF;
                        3: dvd = 32'h8000_0000;
                        4: dvd = 32'hFFFF_FFFF;
                        default: dvd = 32'h0000_FFFF;
                    endcase
                    case ($urandom_range(0, 5))
                        0: dvs = 16'h0000;
                        1: dvs = 16'h0001;
                        2: dvs = 16'h7FFF;
                        3: dvs = 16'h8000;
                        4: dvs = 16'hFFFF;
                        default: dvs = 16'($urandom);
                    endcase
                end
                queue_divide(op, dvd, dvs);
                if ($urandom_range(0, 99) == 0) begin
                    queue_control(STEP_DRAIN, 1'b0);
                end
            end
        end
        queue_control(STEP_DRAIN, 1'b0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every planned step is done and every result has come back.
        @(negedge i_clk);
        while (divide_plan.size() != 0 || start || i_cfg_valid || outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_costs.size() != 0) begin
            report_mismatch($sformatf("%0d cycle counts never arrived", pending_costs.size()));
        end

        $display("Checked %0d cycle counts from %0d unsigned and %0d signed divide requests.",
                 n_costs_checked, n_unsigned, n_signed);
        $display("Fast mode was written %0d times; %0d mismatches were found.",
                 n_fast_writes, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake or lost results.
    initial begin : watchdog
        #10_000_000;
        $display("Timed out with %0d cycle counts still outstanding.", pending_costs.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dct_pkg.sv
rtl/dct_front.sv
rtl/dct_queue.sv
rtl/dct_back.sv
rtl/divide_cycle_timing.sv
sim/testbench.sv
